FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold in every cycle outside reset
`define BRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define BRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Types, codes and constants of the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int DEPTH_DEFAULT     = 256;
   localparam int MAX_BURST_DEFAULT = 64;

   localparam int DATA_W  = 8;
   localparam int LEN_W   = 7;
   localparam int COUNT_W = 9;
   localparam int BSIZE_W = 9;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 9'd256;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_SIZE = 1'd0;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_BURST = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_BURST = 1'b1
   } state_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic       emit;
      status_type status;
      logic       last;
      logic       data_sel;
   } cmd_type;

   typedef struct packed {
      logic             empty;
      logic             full;
      logic [LEN_W-1:0] burst_len;
   } dp_status_type;

endpackage

FILE: sv/byte_ring_fifo_top.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_top
// Byte FIFO in a circular store with a programmable wrap size.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Push, pop and clear
// each return a single result, which shows on rsp_valid in the next
// cycle, so these can be issued back to back. A burst pop of n bytes keeps busy
// high until its last byte is read and returns one byte per cycle, paced by
// the single read port of the byte store; results start the cycle after the
// request and the last one carries rsp_last. Results cannot be held off:
// sample them on every cycle with rsp_valid high. No initialization pass is
// needed after reset. Change buffer_size only while no results are outstanding.
// ----------------------------------------------------------------------------
module byte_ring_fifo_top
   import brf_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [DATA_W-1:0]     req_push_data,
   input  logic [LEN_W-1:0]      req_read_len,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [DATA_W-1:0]     rsp_data_out,
   output logic                  rsp_last,
   output logic [COUNT_W-1:0]    rsp_stored_count,
   output logic [COUNT_W-1:0]    rsp_free_space,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [BSIZE_W-1:0] buffer_size;
   cmd_type            cmd;
   dp_status_type      dp_status;

   brf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .buffer_size (buffer_size)
   );

   brf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .dp_status     (dp_status),
      .cmd           (cmd),
      .busy          (busy)
   );

   brf_dp #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_push_data    (req_push_data),
      .req_read_len     (req_read_len),
      .buffer_size      (buffer_size),
      .dp_status        (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_last         (rsp_last),
      .rsp_stored_count (rsp_stored_count),
      .rsp_free_space   (rsp_free_space)
   );

endmodule

FILE: sv/brf_csr.sv
// ----------------------------------------------------------------------------
// brf_csr
// Configuration register file: buffer size register on an APB-style port.
// ----------------------------------------------------------------------------
module brf_csr
   import brf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [BSIZE_W-1:0]    buffer_size
);

   logic [BSIZE_W-1:0]   bsize_ff;
   logic [BSIZE_W-1:0]   bsize_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && (reg_idx == REG_BUFFER_SIZE);

   always_comb begin
      bsize_in = bsize_ff;
      if (wr_en) begin
         bsize_in = pwdata[BSIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= BSIZE_RESET;
      end else begin
         bsize_ff <= bsize_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_BUFFER_SIZE) begin
         prdata = {{(CSR_DATA_W-BSIZE_W){1'b0}}, bsize_ff};
      end
   end

   assign pready      = 1'b1;
   assign buffer_size = bsize_ff;

endmodule

FILE: sv/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Request sequencer: decodes operations and steps burst pops byte by byte.
// ----------------------------------------------------------------------------
module brf_ctrl
   import brf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_operation,
   input  dp_status_type dp_status,
   output cmd_type       cmd,
   output logic          busy
);

   state_type        state_ff;
   state_type        state_in;
   logic [LEN_W-1:0] remain_ff;
   logic [LEN_W-1:0] remain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               case (op_type'(req_operation))
                  OP_PUSH: begin
                     if (dp_status.full) begin
                        cmd.status = STATUS_FULL;
                     end else begin
                        cmd.push   = 1'b1;
                        cmd.status = STATUS_OK;
                     end
                  end
                  OP_POP: begin
                     if (dp_status.empty) begin
                        cmd.status = STATUS_EMPTY;
                     end else begin
                        cmd.pop      = 1'b1;
                        cmd.data_sel = 1'b1;
                        cmd.status   = STATUS_OK;
                     end
                  end
                  OP_BURST: begin
                     if (dp_status.empty) begin
                        cmd.status = STATUS_EMPTY;
                     end else begin
                        cmd.pop      = 1'b1;
                        cmd.data_sel = 1'b1;
                        cmd.status   = STATUS_OK;
                        cmd.last     = (dp_status.burst_len == LEN_W'(1));
                        remain_in    = dp_status.burst_len - LEN_W'(1);
                        if (dp_status.burst_len != LEN_W'(1)) begin
                           state_in = ST_BURST;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     cmd.clear  = 1'b1;
                     cmd.status = STATUS_OK;
                  end
                  default: begin
                     cmd.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_BURST: begin
            cmd.emit     = 1'b1;
            cmd.pop      = 1'b1;
            cmd.data_sel = 1'b1;
            cmd.status   = STATUS_OK;
            cmd.last     = (remain_ff == LEN_W'(1));
            remain_in    = remain_ff - LEN_W'(1);
            if (remain_ff == LEN_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: sv/brf_dp.sv
// ----------------------------------------------------------------------------
// brf_dp
// Datapath: byte store, wrapping pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module brf_dp
   import brf_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [DATA_W-1:0]  req_push_data,
   input  logic [LEN_W-1:0]   req_read_len,
   input  logic [BSIZE_W-1:0] buffer_size,
   output dp_status_type      dp_status,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [DATA_W-1:0]  rsp_data_out,
   output logic               rsp_last,
   output logic [COUNT_W-1:0] rsp_stored_count,
   output logic [COUNT_W-1:0] rsp_free_space
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = (PTR_W + 1 > BSIZE_W) ? PTR_W + 1 : BSIZE_W;

   logic [DATA_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] fill_ff;
   logic [COUNT_W-1:0] fill_in;
   logic [DATA_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_last_ff;
   logic               data_sel_ff;

   logic [CMP_W-1:0]   eff_ext;
   logic [CMP_W-1:0]   bsize_ext;
   logic [CMP_W-1:0]   fill_ext;
   logic [CMP_W-1:0]   wr_next_ext;
   logic [CMP_W-1:0]   rd_next_ext;
   logic [PTR_W-1:0]   wr_adv;
   logic [PTR_W-1:0]   rd_adv;
   logic [LEN_W-1:0]   len_min1;
   logic [LEN_W-1:0]   len_sat;

   // effective size: register value capped at the store depth
   assign bsize_ext = CMP_W'(buffer_size);
   assign eff_ext   = (bsize_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : bsize_ext;
   assign fill_ext  = CMP_W'(fill_ff);

   assign wr_next_ext = CMP_W'(wr_ptr_ff) + CMP_W'(1);
   assign rd_next_ext = CMP_W'(rd_ptr_ff) + CMP_W'(1);

   assign wr_adv = (wr_next_ext >= eff_ext || wr_next_ext >= CMP_W'(DEPTH)) ?
                   '0 : wr_next_ext[PTR_W-1:0];
   assign rd_adv = (rd_next_ext >= eff_ext || rd_next_ext >= CMP_W'(DEPTH)) ?
                   '0 : rd_next_ext[PTR_W-1:0];

   // burst length: zero means one, capped at MAX_BURST and at the fill count
   assign len_min1 = (req_read_len == '0) ? LEN_W'(1) : req_read_len;
   assign len_sat  = (len_min1 > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : len_min1;

   always_comb begin
      dp_status.empty     = (fill_ff == '0);
      dp_status.full      = (fill_ext >= eff_ext);
      dp_status.burst_len = (COUNT_W'(len_sat) > fill_ff) ? fill_ff[LEN_W-1:0] : len_sat;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (cmd.push) begin
         wr_ptr_in = wr_adv;
         fill_in   = fill_ff + COUNT_W'(1);
      end
      if (cmd.pop) begin
         rd_ptr_in = rd_adv;
         fill_in   = fill_ff - COUNT_W'(1);
      end
      if (cmd.clear) begin
         rd_ptr_in = wr_ptr_ff;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= cmd.status;
      rsp_last_ff   <= cmd.last;
      data_sel_ff   <= cmd.data_sel;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= req_push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_data_out     = data_sel_ff ? rd_data_ff : '0;
   assign rsp_last         = rsp_last_ff;
   assign rsp_stored_count = fill_ff;
   assign rsp_free_space   = (fill_ext < eff_ext) ?
                             COUNT_W'(eff_ext - fill_ext) : '0;

endmodule

FILE: sv/brf_checker.sv
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks of the byte ring FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brf_checker
   import brf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status,
   input logic [DATA_W-1:0]  rsp_data_out,
   input logic               rsp_last,
   input logic [COUNT_W-1:0] rsp_stored_count,
   input logic [COUNT_W-1:0] rsp_free_space
);

   `BRF_ASSERT_NEXT(a_req_gives_result, clock, reset, start && !busy, rsp_valid, "request gave no result")

   `BRF_ASSERT(a_fail_is_single, clock, reset, !(rsp_valid && rsp_status != STATUS_OK) || (rsp_last && rsp_data_out == '0), "failed request result not final or carries data")

   `BRF_ASSERT(a_full_no_space, clock, reset, !(rsp_valid && rsp_status == STATUS_FULL) || rsp_free_space == '0, "push rejected with free space left")

   `BRF_ASSERT(a_burst_busy, clock, reset, !(rsp_valid && !rsp_last) || busy, "burst in flight without busy")

   `BRF_ASSERT_NEXT(a_burst_step, clock, reset, rsp_valid && !rsp_last, rsp_valid && rsp_stored_count == COUNT_W'($past(rsp_stored_count) - COUNT_W'(1)), "burst byte missing or count off")

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_data_out     (rsp_data_out),
   .rsp_last         (rsp_last),
   .rsp_stored_count (rsp_stored_count),
   .rsp_free_space   (rsp_free_space)
);
